### hw/rtl/hwpm_pkg.sv
package hwpm_pkg;

    // field widths
    localparam int CNT_W  = 7;
    localparam int PIDX_W = 6;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 32;
    localparam int CFG_W  = 7;
    localparam int CIDX_W = 1;

    // largest mismatch count a window counter can hold
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_PATTERN_LENGTH    = 1'b0;
    localparam logic [CIDX_W-1:0] REG_MAX_SUBSTITUTIONS = 1'b1;

    // control broadcast along the cell row
    typedef struct packed {
        logic              text_en;
        logic              clear;
        logic              load_en;
        logic [PIDX_W-1:0] pattern_index;
        logic [BYTE_W-1:0] data_byte;
    } cell_ctl_t;

    // item waiting between the cell row and the report stage
    typedef struct packed {
        logic             full;
        logic [POS_W-1:0] pos;
    } stage_t;

endpackage

### hw/rtl/hwpm_cell.sv
module hwpm_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hwpm_pkg::cell_ctl_t             ctl,
    input  logic [hwpm_pkg::CNT_W-1:0]      cnt_in,
    output logic [hwpm_pkg::CNT_W-1:0]      cnt_out
);
    import hwpm_pkg::*;

    logic [BYTE_W-1:0] pat_reg;
    logic [CNT_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  sum_next;
    logic [CNT_W-1:0]  base;
    logic [CNT_W:0]    wide_sum;
    logic              mism;
    logic              wr_hit;

    // pattern byte write for this position
    assign wr_hit = ctl.load_en && (32'(ctl.pattern_index) == 32'(CELL_INDEX));

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            pat_reg <= ctl.data_byte;
        end
    end

    // add one mismatch to the window count handed over from the left, saturating
    assign base     = ctl.clear ? '0 : cnt_in;
    assign mism     = (pat_reg != ctl.data_byte);
    assign wide_sum = {1'b0, base} + {{CNT_W{1'b0}}, mism};

    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.text_en)
        begin
            sum_next = wide_sum[CNT_W] ? CNT_MAX : wide_sum[CNT_W-1:0];
        end
        else if (ctl.clear)
        begin
            sum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign cnt_out = sum_reg;

endmodule

### hw/rtl/hwpm_report.sv
module hwpm_report #(
    parameter int PATTERN_MAX = 64,
    parameter int SEL_W       = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          stage_valid,
    input  hwpm_pkg::stage_t              stage,
    input  logic [hwpm_pkg::CNT_W-1:0]    sums [PATTERN_MAX],
    input  logic [SEL_W-1:0]              sel,
    input  logic [hwpm_pkg::CFG_W-1:0]    subst_limit,
    input  logic                          clear_match,
    output logic                          advance,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          window_full,
    output logic                          within_limit,
    output logic [hwpm_pkg::CNT_W-1:0]    mismatch_count,
    output logic [hwpm_pkg::POS_W-1:0]    end_position,
    output logic                          any_match
);
    import hwpm_pkg::*;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             match_reg;
    logic             match_next;
    logic             full_reg;
    logic             within_reg;
    logic [CNT_W-1:0] count_reg;
    logic [POS_W-1:0] pos_reg;
    logic             any_reg;
    logic [CNT_W-1:0] count;
    logic             in_limit;

    assign advance = stage_valid && (!out_valid_reg || !out_stall);

    // pick the counter of the window that ends here and judge it
    assign count    = stage.full ? sums[sel] : '0;
    assign in_limit = stage.full && (count <= subst_limit);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // sticky match flag, cleared by a new text
    always_comb
    begin
        match_next = match_reg;
        if (clear_match)
        begin
            match_next = 1'b0;
        end
        else if (advance && in_limit)
        begin
            match_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            match_reg     <= match_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            full_reg   <= stage.full;
            within_reg <= in_limit;
            count_reg  <= count;
            pos_reg    <= stage.pos;
            any_reg    <= match_reg || in_limit;
        end
    end

    assign out_valid      = out_valid_reg;
    assign window_full    = full_reg;
    assign within_limit   = within_reg;
    assign mismatch_count = count_reg;
    assign end_position   = pos_reg;
    assign any_match      = any_reg;

endmodule

### hw/rtl/hamming_window_pattern_matcher_top.sv
// Hamming-distance window matcher: approximate matching with substitutions only.
// Input channel (in_valid / in_stall): op 0 writes data_byte into pattern slot
// pattern_index and gives no result; op 1 feeds one text byte and gives one
// result item. text_start clears the window counters, the position and the
// sticky any_match flag before the item is handled.
// Configuration (cfg_we / cfg_index / cfg_data): index 0 pattern_length,
// index 1 substitution limit; write only while the block is idle.
// A text item's result goes through a staging register, then the output register,
// before it is valid on the output channel. Throughput: one item per cycle while
// out_stall lets results go; every window counter sits in its own cell of the row
// and all cells shift together on each text byte.
// When out_stall holds a result, one more item can wait behind it; after that
// in_stall rises until the output register is taken.
// Reset clears all counters, the position, the match flag and both handshake
// registers; pattern_length returns to 1 and the substitution limit to 0. The
// pattern store keeps no reset value and must be loaded before text is fed.
module hamming_window_pattern_matcher_top #(
    parameter int PATTERN_MAX = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hwpm_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [hwpm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [hwpm_pkg::PIDX_W-1:0]   pattern_index,
    input  logic [hwpm_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          text_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          window_full,
    output logic                          within_limit,
    output logic [hwpm_pkg::CNT_W-1:0]    mismatch_count,
    output logic [hwpm_pkg::POS_W-1:0]    end_position,
    output logic                          any_match
);
    import hwpm_pkg::*;

    localparam int SEL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [CFG_W-1:0] pattern_length_reg;
    logic [CFG_W-1:0] max_subst_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             stage_valid_reg;
    logic             stage_valid_next;
    stage_t           stage_reg;
    logic             advance;
    logic             in_acc;
    logic             text_acc;
    logic [POS_W-1:0] pos_cur;
    logic [31:0]      last_idx;
    logic [SEL_W-1:0] sel;
    cell_ctl_t        ctl;
    logic [CNT_W-1:0] sums [PATTERN_MAX];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= CFG_W'(1);
            max_subst_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LENGTH:    pattern_length_reg <= cfg_data;
                REG_MAX_SUBSTITUTIONS: max_subst_reg      <= cfg_data;
                default:               ;
            endcase
        end
    end

    // index of the last pattern byte, clamped to the cell row
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            last_idx = 32'd0;
        end
        else if (32'(pattern_length_reg) > 32'(PATTERN_MAX))
        begin
            last_idx = 32'(PATTERN_MAX - 1);
        end
        else
        begin
            last_idx = 32'(pattern_length_reg) - 32'd1;
        end
    end
    assign sel = last_idx[SEL_W-1:0];

    // input handshake: hold off while the staged item cannot move on
    assign in_stall = stage_valid_reg && !advance;
    assign in_acc   = in_valid && !in_stall;
    assign text_acc = in_acc && (op == OP_TEXT);

    // control broadcast to the cells
    assign ctl.text_en       = text_acc;
    assign ctl.clear         = in_acc && text_start;
    assign ctl.load_en       = in_acc && (op == OP_LOAD);
    assign ctl.pattern_index = pattern_index;
    assign ctl.data_byte     = data_byte;

    // row of cells, each handing its count to the right
    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        if (j == 0)
        begin : g_first
            hwpm_cell #(
                .CELL_INDEX(j)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .cnt_in ('0),
                .cnt_out(sums[j])
            );
        end
        else
        begin : g_rest
            hwpm_cell #(
                .CELL_INDEX(j)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .cnt_in (sums[j-1]),
                .cnt_out(sums[j])
            );
        end
    end

    // text position, saturating
    assign pos_cur = text_start ? '0 : pos_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (text_acc)
        begin
            pos_next = (pos_cur == POS_MAX) ? POS_MAX : pos_cur + POS_W'(1);
        end
        else if (in_acc && text_start)
        begin
            pos_next = '0;
        end
    end

    // staged item waiting for the report stage
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (text_acc)
        begin
            stage_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_acc)
        begin
            stage_reg.full <= (32'(pos_cur) >= last_idx);
            stage_reg.pos  <= pos_cur;
        end
    end

    hwpm_report #(
        .PATTERN_MAX(PATTERN_MAX),
        .SEL_W      (SEL_W)
    ) u_report (
        .clk              (clk),
        .rst_n            (rst_n),
        .stage_valid      (stage_valid_reg),
        .stage            (stage_reg),
        .sums             (sums),
        .sel              (sel),
        .subst_limit      (max_subst_reg),
        .clear_match      (in_acc && text_start),
        .advance          (advance),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .window_full      (window_full),
        .within_limit     (within_limit),
        .mismatch_count   (mismatch_count),
        .end_position     (end_position),
        .any_match        (any_match)
    );

endmodule

### sim/tb_hamming_window_pattern_matcher_top.sv
module tb_hamming_window_pattern_matcher_top;
    import hwpm_pkg::*;

    localparam int PATTERN_MAX = 64;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 6;
    localparam int STALL_LIMIT = 5000;

    // one reported window, in output port order
    typedef struct packed {
        logic             full;
        logic             in_limit;
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] pos;
        logic             any;
    } window_report_t;

    // mirror of the matcher plus the queue of windows still to come out
    class window_scoreboard;
        logic [BYTE_W-1:0] pattern_mem [PATTERN_MAX];
        logic [CNT_W-1:0]  counters [PATTERN_MAX];
        logic [POS_W-1:0]  position;
        logic              seen;
        logic [CFG_W-1:0]  length_reg;
        logic [CFG_W-1:0]  subs_reg;
        window_report_t    expected_windows [$];
        int                mismatches;

        function new();
            foreach (pattern_mem[i])
                pattern_mem[i] = '0;
            foreach (counters[i])
                counters[i] = '0;
            position   = '0;
            seen       = 1'b0;
            length_reg = 7'd1;
            subs_reg   = 7'd0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_PATTERN_LENGTH)
                length_reg = val;
            else if (idx == REG_MAX_SUBSTITUTIONS)
                subs_reg = val;
        endfunction

        // saturating add of one mismatch
        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c, logic differs);
            if (differs && c != CNT_MAX)
                return c + 1'b1;
            return c;
        endfunction

        function void note_item(logic op_i, logic [PIDX_W-1:0] idx,
                                logic [BYTE_W-1:0] b, logic start);
            int unsigned    len;
            int             j;
            window_report_t w;
            // text start clears before the item is handled
            if (start)
            begin
                foreach (counters[i])
                    counters[i] = '0;
                position = '0;
                seen     = 1'b0;
            end
            if (op_i == OP_LOAD)
            begin
                pattern_mem[idx] = b;
                return;
            end
            len = length_reg;
            if (len == 0)
                len = 1;
            if (len > PATTERN_MAX)
                len = PATTERN_MAX;
            // close the window ending at this byte
            w      = '0;
            w.pos  = position;
            w.full = (position >= len - 1);
            if (w.full)
            begin
                w.count    = bump(counters[len-1], pattern_mem[len-1] != b);
                w.in_limit = (w.count <= subs_reg);
                if (w.in_limit)
                    seen = 1'b1;
            end
            // every open window moves one slot along
            for (j = PATTERN_MAX - 1; j >= 1; j--)
                counters[j] = bump(counters[j-1], pattern_mem[j-1] != b);
            counters[0] = '0;
            if (position != POS_MAX)
                position++;
            w.any = seen;
            expected_windows.push_back(w);
        endfunction

        function void check_result(window_report_t got);
            window_report_t want;
            if (expected_windows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: full=%0b within=%0b count=%0d pos=%0d any=%0b",
                             got.full, got.in_limit, got.count, got.pos, got.any);
                return;
            end
            want = expected_windows.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"window mismatch: expected full=%0b within=%0b count=%0d pos=%0d",
                              " any=%0b, got full=%0b within=%0b count=%0d pos=%0d any=%0b"},
                             want.full, want.in_limit, want.count, want.pos, want.any,
                             got.full, got.in_limit, got.count, got.pos, got.any);
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_we        = 1'b0;
    logic [CIDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]  cfg_data      = '0;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic              op            = OP_LOAD;
    logic [PIDX_W-1:0] pattern_index = '0;
    logic [BYTE_W-1:0] data_byte     = '0;
    logic              text_start    = 1'b0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic              window_full;
    logic              within_limit;
    logic [CNT_W-1:0]  mismatch_count;
    logic [POS_W-1:0]  end_position;
    logic              any_match;

    window_scoreboard sb;
    int send_pct      = 0;
    int recv_pct      = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    hamming_window_pattern_matcher_top #(
        .PATTERN_MAX(PATTERN_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .pattern_index(pattern_index),
        .data_byte(data_byte),
        .text_start(text_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .window_full(window_full),
        .within_limit(within_limit),
        .mismatch_count(mismatch_count),
        .end_position(end_position),
        .any_match(any_match)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_pct);
    end

    // monitor both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall)
                sb.check_result(window_report_t'({window_full, within_limit, mismatch_count,
                                                  end_position, any_match}));
            if (in_valid && !in_stall)
                sb.note_item(op, pattern_index, data_byte, text_start);
        end
    end

    // watchdog on cycles with no item moving
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("hamming_window_pattern_matcher_top regression: fail");
        $finish;
    end

    // offer one item after a random gap, hold it until taken
    task automatic send_item(logic op_i, logic [PIDX_W-1:0] idx,
                             logic [BYTE_W-1:0] b, logic start);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= op_i;
        pattern_index <= idx;
        data_byte     <= b;
        text_start    <= start;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending and wait for every outstanding window
    task automatic drain_block(int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_windows.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain_block(SETTLE);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // random text: mostly near copies of the pattern, some noise and reloads
    task automatic run_phase(int len, int subs, int s_pct, int r_pct, int n_items,
                             bit long_hold);
        int                n;
        int                i;
        int unsigned       k;
        int unsigned       slot;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] burst [$];
        write_reg(REG_PATTERN_LENGTH, CFG_W'(len));
        write_reg(REG_MAX_SUBSTITUTIONS, CFG_W'(subs));
        send_pct = s_pct;
        recv_pct <= r_pct;
        if (long_hold)
            hold_requests <= hold_requests + 1;
        for (n = 0; n < n_items; n++)
        begin
            if (n == n_items / 2)
                drain_block(0);
            if ($urandom_range(99) < 4)
                send_item(OP_LOAD, PIDX_W'($urandom_range(PATTERN_MAX - 1)),
                          BYTE_W'($urandom), $urandom_range(9) == 0);
            else
            begin
                if (burst.size() == 0)
                begin
                    if ($urandom_range(99) < 75)
                    begin
                        for (i = 0; i < len; i++)
                            burst.push_back(sb.pattern_mem[i]);
                        k = $urandom_range(subs + 2 > len ? len : subs + 2);
                        repeat (k)
                        begin
                            slot = $urandom_range(len - 1);
                            burst[slot] = burst[slot] ^ BYTE_W'($urandom_range(255, 1));
                        end
                    end
                    else
                        repeat ($urandom_range(6, 1)) burst.push_back(BYTE_W'($urandom));
                end
                b = burst.pop_front();
                send_item(OP_TEXT, PIDX_W'($urandom), b, $urandom_range(49) == 0);
            end
        end
    endtask

    // stimulus
    initial
    begin
        int i;
        int len_r;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every pattern slot, byte extremes at both ends
        for (i = 0; i < PATTERN_MAX; i++)
            send_item(OP_LOAD, PIDX_W'(i),
                      i == 0 ? 8'h00 : (i == PATTERN_MAX - 1 ? 8'hFF : BYTE_W'($urandom)),
                      1'b0);

        // one-byte window: hit, miss, both byte extremes
        send_item(OP_TEXT, '0, 8'h00, 1'b1);
        send_item(OP_TEXT, '1, 8'hFF, 1'b0);
        send_item(OP_TEXT, '0, 8'hFF, 1'b1);
        // text start on a pattern load still clears
        send_item(OP_LOAD, '1, 8'hFF, 1'b1);
        send_item(OP_TEXT, '0, 8'h00, 1'b0);

        // length changed in the middle of a text
        write_reg(REG_PATTERN_LENGTH, 7'd3);
        write_reg(REG_MAX_SUBSTITUTIONS, 7'd1);
        send_item(OP_TEXT, '0, sb.pattern_mem[0], 1'b0);
        // exact window, then one and two substitutions
        send_item(OP_TEXT, '0, sb.pattern_mem[0], 1'b1);
        send_item(OP_TEXT, '0, sb.pattern_mem[1], 1'b0);
        send_item(OP_TEXT, '0, sb.pattern_mem[2], 1'b0);
        send_item(OP_TEXT, '0, ~sb.pattern_mem[0], 1'b0);
        send_item(OP_TEXT, '0, sb.pattern_mem[1], 1'b0);
        send_item(OP_TEXT, '0, sb.pattern_mem[2], 1'b0);
        send_item(OP_TEXT, '0, ~sb.pattern_mem[0], 1'b0);
        send_item(OP_TEXT, '0, ~sb.pattern_mem[1], 1'b0);
        send_item(OP_TEXT, '0, sb.pattern_mem[2], 1'b0);

        // limit so large that every full window matches
        write_reg(REG_MAX_SUBSTITUTIONS, 7'd64);
        repeat (3) send_item(OP_TEXT, '0, BYTE_W'($urandom), 1'b0);

        // random phases over settings and idling modes
        run_phase(1, 0, 0, 0, 200, 1'b0);
        run_phase(64, 64, 75, 0, 200, 1'b0);
        run_phase(64, 0, 0, 75, 200, 1'b0);
        run_phase(4, 1, 14, 14, 200, 1'b0);
        len_r = $urandom_range(12, 2);
        run_phase(len_r, $urandom_range(len_r), 0, 0, 250, 1'b1);
        run_phase(7, 2, 0, 75, 200, 1'b0);
        len_r = $urandom_range(63, 1);
        run_phase(len_r, $urandom_range(64), 14, 14, 200, 1'b0);
        run_phase(3, 0, 75, 0, 200, 1'b0);

        // wait out the last windows
        drain_block(SETTLE);
        if (sb.mismatches == 0 && sb.expected_windows.size() == 0)
            $display("hamming_window_pattern_matcher_top regression: pass");
        else
            $display("hamming_window_pattern_matcher_top regression: fail");
        $finish;
    end

endmodule
